FILE: hw/rtl/hmbd_pkg.sv
// Package with the types, character codes and matcher steps of the HTTP boundary detector.
`default_nettype none

package hmbd_pkg;

  // Character codes used by the matchers and the length parser.
  localparam logic [7:0] CHAR_CR      = 8'd13;
  localparam logic [7:0] CHAR_LF      = 8'd10;
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_NINE    = 8'd57;
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_LOWER_C = 8'd99;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  // Pattern lengths.
  localparam logic [3:0] FIELD_LEN = 4'd15;
  localparam logic [2:0] CRLF_LEN  = 3'd4;
  localparam logic [1:0] LFLF_LEN  = 2'd2;
  localparam logic [2:0] CHUNK_LEN = 3'd7;

  // Content-Length parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_NONE   = 4'b0001,
    PH_BLANK  = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_e;

  // Request handed from the input register to the scanner.
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       restart;
  } req_t;

  // Result of scanning one byte.
  typedef struct packed {
    logic        complete;
    logic [31:0] message_length;
    logic        in_body;
    logic        length_overflow;
  } result_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  // Lower-case spelling of "content-length:".
  function automatic logic [7:0] field_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'd99;   // c
      4'd1:    ch = 8'd111;  // o
      4'd2:    ch = 8'd110;  // n
      4'd3:    ch = 8'd116;  // t
      4'd4:    ch = 8'd101;  // e
      4'd5:    ch = 8'd110;  // n
      4'd6:    ch = 8'd116;  // t
      4'd7:    ch = 8'd45;   // -
      4'd8:    ch = 8'd108;  // l
      4'd9:    ch = 8'd101;  // e
      4'd10:   ch = 8'd110;  // n
      4'd11:   ch = 8'd103;  // g
      4'd12:   ch = 8'd116;  // t
      4'd13:   ch = 8'd104;  // h
      4'd14:   ch = 8'd58;   // :
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [3:0] field_step(input logic [3:0] st_in, input logic [7:0] lc);
    logic [3:0] st;
    st = (st_in >= FIELD_LEN) ? 4'd0 : st_in;
    if (field_char(st) == lc) begin
      return st + 4'd1;
    end
    return (lc == CHAR_LOWER_C) ? 4'd1 : 4'd0;
  endfunction

  function automatic logic [2:0] crlf_step(input logic [2:0] st, input logic [7:0] c);
    logic [2:0] nx;
    unique case (st)
      3'd1:    nx = (c == CHAR_LF) ? 3'd2 : ((c == CHAR_CR) ? 3'd1 : 3'd0);
      3'd2:    nx = (c == CHAR_CR) ? 3'd3 : 3'd0;
      3'd3:    nx = (c == CHAR_LF) ? 3'd4 : ((c == CHAR_CR) ? 3'd1 : 3'd0);
      default: nx = (c == CHAR_CR) ? 3'd1 : 3'd0;
    endcase
    return nx;
  endfunction

  function automatic logic [1:0] lflf_step(input logic [1:0] st, input logic [7:0] c);
    logic [1:0] nx;
    unique case (st)
      2'd1:    nx = (c == CHAR_LF) ? 2'd2 : 2'd0;
      default: nx = (c == CHAR_LF) ? 2'd1 : 2'd0;
    endcase
    return nx;
  endfunction

  // Matcher for CR LF '0' CR LF CR LF, with the fallbacks of its failure table folded in.
  function automatic logic [2:0] chunk_step(input logic [2:0] st, input logic [7:0] c);
    logic [2:0] nx;
    unique case (st)
      3'd1:    nx = (c == CHAR_LF) ? 3'd2 : ((c == CHAR_CR) ? 3'd1 : 3'd0);
      3'd2:    nx = (c == CHAR_ZERO) ? 3'd3 : ((c == CHAR_CR) ? 3'd1 : 3'd0);
      3'd3:    nx = (c == CHAR_CR) ? 3'd4 : 3'd0;
      3'd4:    nx = (c == CHAR_LF) ? 3'd5 : ((c == CHAR_CR) ? 3'd1 : 3'd0);
      3'd5:    nx = (c == CHAR_CR) ? 3'd6 : ((c == CHAR_ZERO) ? 3'd3 : 3'd0);
      3'd6:    nx = (c == CHAR_LF) ? 3'd7 : ((c == CHAR_CR) ? 3'd1 : 3'd0);
      default: nx = (c == CHAR_CR) ? 3'd1 : 3'd0;
    endcase
    return nx;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hmbd_in_if.sv
// Interface of the byte input channel.
`default_nettype none

interface hmbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/hmbd_out_if.sv
// Interface of the result output channel.
`default_nettype none

interface hmbd_out_if;
  logic        valid;
  logic        ready;
  logic        complete;
  logic [31:0] message_length;
  logic        in_body;
  logic        length_overflow;

  modport source (output valid, output complete, output message_length, output in_body,
                  output length_overflow, input ready);
  modport sink   (input valid, input complete, input message_length, input in_body,
                  input length_overflow, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/hmbd_scan.sv
// Message state registers and the single-pass scan of one byte.
`default_nettype none

module hmbd_scan #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hmbd_pkg::req_t    req_i,
  input  wire logic              chunk_wait_i,
  output hmbd_pkg::result_t      result_o
);

  localparam int TW = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [COUNT_BITS-1:0] byte_count_q, byte_count_d;
  logic                  header_end_q, header_end_d;
  logic [COUNT_BITS-1:0] header_len_q, header_len_d;
  logic [2:0]            crlf_q, crlf_d;
  logic [1:0]            lflf_q, lflf_d;
  logic [3:0]            field_q, field_d;
  hmbd_pkg::phase_e      phase_q, phase_d;
  logic [31:0]           clen_q, clen_d;
  logic [2:0]            chunk_q, chunk_d;
  logic                  sat_q, sat_d;

  logic [7:0]  c;
  logic [7:0]  lc;
  logic        in_header;
  logic        digit;
  logic [3:0]  digit_val;
  logic [35:0] clen_x10;
  logic [TW-1:0] target;
  logic [TW-1:0] len;
  logic        done;
  logic        found;

  always_comb begin
    c         = req_i.data_byte;
    lc        = hmbd_pkg::to_lower(c);
    digit     = (c >= hmbd_pkg::CHAR_ZERO) && (c <= hmbd_pkg::CHAR_NINE);
    digit_val = 4'(c - hmbd_pkg::CHAR_ZERO);

    // A restart discards the message state before this byte is looked at.
    if (req_i.restart) begin
      byte_count_d = '0;
      header_end_d = 1'b0;
      header_len_d = '0;
      crlf_d       = '0;
      lflf_d       = '0;
      field_d      = '0;
      phase_d      = hmbd_pkg::PH_NONE;
      clen_d       = '0;
      chunk_d      = '0;
      sat_d        = 1'b0;
    end else begin
      byte_count_d = byte_count_q;
      header_end_d = header_end_q;
      header_len_d = header_len_q;
      crlf_d       = crlf_q;
      lflf_d       = lflf_q;
      field_d      = field_q;
      phase_d      = phase_q;
      clen_d       = clen_q;
      chunk_d      = chunk_q;
      sat_d        = sat_q;
    end

    in_header = !header_end_d;

    if (byte_count_d == COUNT_MAX) begin
      sat_d = 1'b1;
    end else begin
      byte_count_d = byte_count_d + COUNT_BITS'(1);
    end

    chunk_d = hmbd_pkg::chunk_step((chunk_d == hmbd_pkg::CHUNK_LEN) ? 3'd0 : chunk_d, c);

    clen_x10 = ({4'd0, clen_d} << 3) + ({4'd0, clen_d} << 1) + {32'd0, digit_val};

    if (in_header) begin
      unique case (phase_d)
        hmbd_pkg::PH_BLANK: begin
          if (digit) begin
            clen_d  = {28'd0, digit_val};
            phase_d = hmbd_pkg::PH_DIGITS;
          end else if (c != hmbd_pkg::CHAR_SPACE && c != hmbd_pkg::CHAR_TAB) begin
            phase_d = hmbd_pkg::PH_DONE;
          end
        end
        hmbd_pkg::PH_DIGITS: begin
          if (digit) begin
            if (clen_x10[35:32] != 4'd0) begin
              clen_d = '1;
              sat_d  = 1'b1;
            end else begin
              clen_d = clen_x10[31:0];
            end
          end else begin
            phase_d = hmbd_pkg::PH_DONE;
          end
        end
        hmbd_pkg::PH_NONE: begin
          field_d = hmbd_pkg::field_step(field_d, lc);
          if (field_d == hmbd_pkg::FIELD_LEN) begin
            phase_d = hmbd_pkg::PH_BLANK;
            field_d = '0;
          end
        end
        default: ;
      endcase

      crlf_d = hmbd_pkg::crlf_step((crlf_d >= hmbd_pkg::CRLF_LEN) ? 3'd0 : crlf_d, c);
      lflf_d = hmbd_pkg::lflf_step((lflf_d >= hmbd_pkg::LFLF_LEN) ? 2'd0 : lflf_d, c);
      if (crlf_d == hmbd_pkg::CRLF_LEN || lflf_d == hmbd_pkg::LFLF_LEN) begin
        header_end_d = 1'b1;
        header_len_d = byte_count_d;
        crlf_d       = '0;
        lflf_d       = '0;
      end
    end

    found  = (phase_d != hmbd_pkg::PH_NONE);
    target = TW'(header_len_d) + TW'(clen_d);
    done   = 1'b0;
    len    = '0;

    if (header_end_d) begin
      if (found) begin
        if (target > TW'(COUNT_MAX)) begin
          target = TW'(COUNT_MAX);
          sat_d  = 1'b1;
        end
        if (TW'(byte_count_d) >= target) begin
          done = 1'b1;
          len  = target;
        end
      end else if (chunk_d == hmbd_pkg::CHUNK_LEN || !chunk_wait_i) begin
        // Without a length field the count is the message length; when the header
        // ends on this very byte the header length equals the count.
        done = 1'b1;
        len  = TW'(byte_count_d);
      end
    end

    result_o.complete        = done;
    result_o.message_length  = len[31:0];
    result_o.in_body         = header_end_d;
    result_o.length_overflow = sat_d;

    if (done) begin
      byte_count_d = '0;
      header_end_d = 1'b0;
      header_len_d = '0;
      crlf_d       = '0;
      lflf_d       = '0;
      field_d      = '0;
      phase_d      = hmbd_pkg::PH_NONE;
      clen_d       = '0;
      chunk_d      = '0;
      sat_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      header_end_q <= 1'b0;
      header_len_q <= '0;
      crlf_q       <= '0;
      lflf_q       <= '0;
      field_q      <= '0;
      phase_q      <= hmbd_pkg::PH_NONE;
      clen_q       <= '0;
      chunk_q      <= '0;
      sat_q        <= 1'b0;
    end else if (req_i.valid) begin
      byte_count_q <= byte_count_d;
      header_end_q <= header_end_d;
      header_len_q <= header_len_d;
      crlf_q       <= crlf_d;
      lflf_q       <= lflf_d;
      field_q      <= field_d;
      phase_q      <= phase_d;
      clen_q       <= clen_d;
      chunk_q      <= chunk_d;
      sat_q        <= sat_d;
    end
  end

  // A message can only end once its header is over.
  a_complete_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.complete |-> result_o.in_body)
    else $error("completion reported before header end");

  a_length_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_o.complete |-> (result_o.message_length == 32'd0))
    else $error("message length set without completion");

  a_clear_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && result_o.complete) |=> (byte_count_q == '0 && !header_end_q && !sat_q))
    else $error("message state not cleared after completion");

  a_field_only_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != hmbd_pkg::PH_NONE) |-> (field_q == 4'd0))
    else $error("field matcher active after the field was found");

endmodule

`default_nettype wire

FILE: hw/rtl/http_message_boundary_detector_top.sv
// Top level of the HTTP message boundary detector with its handshake registers.
//
// The block takes one byte of a received HTTP stream per request and returns one
// result per byte: whether the byte ends a message, the message length, whether
// the header has ended, and whether a length saturated. The header ends at the
// first CRLFCRLF or LFLF; a case-insensitive "Content-Length:" in the header,
// followed by optional blanks and decimal digits, sets the body length. Without
// that field the message ends at the header end, or at the chunk terminator
// CRLF "0" CRLF CRLF while chunk_wait is set (reset value 1). A byte with restart
// set throws away the partial message before it is counted. Throughput is one
// byte per cycle while the receiver keeps taking results; a byte's result passes
// through the input register and then the result register, and the whole scan
// of a byte sits in the single logic pass between those two registers.
// The input side keeps taking requests while a result waits, until both the
// input and the result registers are full. chunk_wait is to be written only
// while no byte is in flight. COUNT_BITS sets the width of the byte counter.
`default_nettype none

module http_message_boundary_detector_top #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_wdata_i,
  hmbd_in_if.sink    in_i,
  hmbd_out_if.source out_o
);

  logic              chunk_wait_q;
  logic              in_vld_q;
  logic [7:0]        in_byte_q;
  logic              in_restart_q;
  logic              out_vld_q;
  hmbd_pkg::result_t out_q;
  hmbd_pkg::result_t result;
  hmbd_pkg::req_t    req;
  logic              advance;
  logic              in_ready;

  // The byte in the input register moves on when the result register is free or
  // is being emptied in this cycle.
  assign advance  = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_ready = !in_vld_q || advance;

  assign req.valid     = advance;
  assign req.data_byte = in_byte_q;
  assign req.restart   = in_restart_q;

  hmbd_scan #(
    .COUNT_BITS(COUNT_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .chunk_wait_i(chunk_wait_q),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_wait_q <= 1'b1;
    end else if (cfg_we_i) begin
      chunk_wait_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_byte_q    <= in_i.data_byte;
      in_restart_q <= in_i.restart;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign in_i.ready            = in_ready;
  assign out_o.valid           = out_vld_q;
  assign out_o.complete        = out_q.complete;
  assign out_o.message_length  = out_q.message_length;
  assign out_o.in_body         = out_q.in_body;
  assign out_o.length_overflow = out_q.length_overflow;

  // A stalled result must not be overwritten by a byte from the input register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |-> !advance)
    else $error("result register overwritten while stalled");

  // An empty pipeline always takes a request.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_vld_q && !out_vld_q) |-> in_i.ready)
    else $error("request refused with empty pipeline");

  a_result_follows_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("scanned byte gave no result");

endmodule

`default_nettype wire

FILE: tb/tb_http_message_boundary_detector_top.sv
// Self-checking testbench of the HTTP message boundary detector top level.
`timescale 1ns / 1ps

module tb_http_message_boundary_detector_top;

  localparam int COUNT_BITS = 32;
  localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
  localparam logic [63:0] VALUE_MAX = 64'h0000_0000_FFFF_FFFF;

  // A byte's result passes through the input and the result register of the block before it leaves.
  localparam int LATENCY        = 2;
  localparam int SETTLE_CYCLES  = LATENCY + 4;
  // The longest quiet stretch of a correct run is the receiver's long
  // hold-off; the watchdog allows several times that.
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 120;
  // Setting of chunk_wait for each random phase, first phase in bit 0.
  localparam logic [4:0] PHASE_CHUNK_WAIT = 5'b10101;

  // Patterns of the matchers, right-aligned, first character highest.
  // The fallback tables hold one 4-bit entry per pattern position.
  localparam logic [119:0] FIELD_TEXT     = "content-length:";
  localparam logic [59:0]  FIELD_FALLBACK = '0;
  localparam logic [31:0]  CRLF_TEXT      = {hmbd_pkg::CHAR_CR, hmbd_pkg::CHAR_LF,
                                             hmbd_pkg::CHAR_CR, hmbd_pkg::CHAR_LF};
  localparam logic [15:0]  CRLF_FALLBACK  = 16'h0012;
  localparam logic [15:0]  LFLF_TEXT      = {hmbd_pkg::CHAR_LF, hmbd_pkg::CHAR_LF};
  localparam logic [7:0]   LFLF_FALLBACK  = 8'h01;
  localparam logic [55:0]  CHUNK_TEXT     = {hmbd_pkg::CHAR_CR, hmbd_pkg::CHAR_LF,
                                             hmbd_pkg::CHAR_ZERO, hmbd_pkg::CHAR_CR,
                                             hmbd_pkg::CHAR_LF, hmbd_pkg::CHAR_CR,
                                             hmbd_pkg::CHAR_LF};
  localparam logic [27:0]  CHUNK_FALLBACK = 28'h0001212;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } stream_byte_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_MOSTLY,
    RX_PERIODIC
  } rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Every input of the block is held by a variable with a known start value.
  logic       cfg_we      = 1'b0;
  logic       cfg_wdata   = 1'b0;
  logic       drv_valid   = 1'b0;
  logic [7:0] drv_data    = 8'h00;
  logic       drv_restart = 1'b0;
  logic       drv_ready   = 1'b0;

  hmbd_in_if  in_ch ();
  hmbd_out_if out_ch ();

  assign in_ch.valid     = drv_valid;
  assign in_ch.data_byte = drv_data;
  assign in_ch.restart   = drv_restart;
  assign out_ch.ready    = drv_ready;

  http_message_boundary_detector_top #(
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Bytes waiting to be offered, and the results that the accepted requests
  // must produce, oldest first.
  stream_byte_t      pending_bytes[$];
  hmbd_pkg::result_t expected_results[$];

  int unsigned queued_total   = 0;
  int unsigned accepted_total = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;
  logic        in_fire        = 1'b0;

  // Predicted state of the detector.
  logic             chunk_wait_cfg = 1'b1;
  logic [63:0]      byte_count     = '0;
  logic             hdr_seen       = 1'b0;
  logic [63:0]      hdr_len        = '0;
  int unsigned      crlf_prog      = 0;
  int unsigned      lflf_prog      = 0;
  int unsigned      field_prog     = 0;
  hmbd_pkg::phase_e parse_phase    = hmbd_pkg::PH_NONE;
  logic [31:0]      content_len    = '0;
  int unsigned      chunk_prog     = 0;
  logic             saturated      = 1'b0;

  // Stimulus shaping.
  logic        next_restart   = 1'b0;
  logic        force_restart  = 1'b0;

  // One step of a prefix matcher with a fallback table, as a string search
  // would do it; returns the number of pattern bytes matched so far.
  function automatic int unsigned advance(input int unsigned st_in, input logic [7:0] c,
                                          input logic [119:0] text,
                                          input logic [59:0] fallback,
                                          input int unsigned len);
    int unsigned st;
    st = (st_in >= len) ? 0 : st_in;
    while (st > 0 && text[8*(len-1-st) +: 8] != c) begin
      st = fallback[4*(len-st) +: 4];
    end
    if (text[8*(len-1-st) +: 8] == c) begin
      st = st + 1;
    end
    return st;
  endfunction

  task automatic reset_message_state();
    byte_count  = '0;
    hdr_seen    = 1'b0;
    hdr_len     = '0;
    crlf_prog   = 0;
    lflf_prog   = 0;
    field_prog  = 0;
    parse_phase = hmbd_pkg::PH_NONE;
    content_len = '0;
    chunk_prog  = 0;
    saturated   = 1'b0;
  endtask

  // Advances the predicted state by one byte and returns the result it causes.
  task automatic scan_byte(input logic [7:0] c, input logic discard,
                           output hmbd_pkg::result_t res);
    logic [7:0]  lc;
    logic [7:0]  digit_val;
    logic        in_hdr;
    logic        digit;
    logic        done;
    logic [63:0] wide;
    logic [63:0] target;
    logic [63:0] msg_len;
    lc = (c >= hmbd_pkg::CHAR_UPPER_A && c <= hmbd_pkg::CHAR_UPPER_Z) ?
         c + hmbd_pkg::CASE_OFFSET : c;
    digit_val = c - hmbd_pkg::CHAR_ZERO;
    done = 1'b0;
    msg_len = '0;
    if (discard) begin
      reset_message_state();
    end
    in_hdr = !hdr_seen;
    if (byte_count >= COUNT_MAX) begin
      saturated = 1'b1;
    end else begin
      byte_count = byte_count + 64'd1;
    end
    // The terminator is looked for over the whole message, header included.
    chunk_prog = advance(chunk_prog, c, CHUNK_TEXT, CHUNK_FALLBACK, hmbd_pkg::CHUNK_LEN);
    if (in_hdr) begin
      digit = (c >= hmbd_pkg::CHAR_ZERO && c <= hmbd_pkg::CHAR_NINE);
      case (parse_phase)
        hmbd_pkg::PH_BLANK: begin
          if (digit) begin
            content_len = {24'd0, digit_val};
            parse_phase = hmbd_pkg::PH_DIGITS;
          end else if (c != hmbd_pkg::CHAR_SPACE && c != hmbd_pkg::CHAR_TAB) begin
            parse_phase = hmbd_pkg::PH_DONE;
          end
        end
        hmbd_pkg::PH_DIGITS: begin
          if (digit) begin
            wide = {32'd0, content_len} * 64'd10 + {56'd0, digit_val};
            if (wide > VALUE_MAX) begin
              wide = VALUE_MAX;
              saturated = 1'b1;
            end
            content_len = wide[31:0];
          end else begin
            parse_phase = hmbd_pkg::PH_DONE;
          end
        end
        hmbd_pkg::PH_NONE: begin
          field_prog = advance(field_prog, lc, FIELD_TEXT, FIELD_FALLBACK,
                               hmbd_pkg::FIELD_LEN);
          if (field_prog == hmbd_pkg::FIELD_LEN) begin
            parse_phase = hmbd_pkg::PH_BLANK;
            field_prog = 0;
          end
        end
        default: begin
        end
      endcase
      crlf_prog = advance(crlf_prog, c, CRLF_TEXT, CRLF_FALLBACK, hmbd_pkg::CRLF_LEN);
      lflf_prog = advance(lflf_prog, c, LFLF_TEXT, LFLF_FALLBACK, hmbd_pkg::LFLF_LEN);
      if (crlf_prog == hmbd_pkg::CRLF_LEN || lflf_prog == hmbd_pkg::LFLF_LEN) begin
        hdr_seen = 1'b1;
        hdr_len = byte_count;
        crlf_prog = 0;
        lflf_prog = 0;
      end
    end
    if (hdr_seen) begin
      if (parse_phase != hmbd_pkg::PH_NONE) begin
        target = hdr_len + {32'd0, content_len};
        if (target > COUNT_MAX) begin
          target = COUNT_MAX;
          saturated = 1'b1;
        end
        if (byte_count >= target) begin
          done = 1'b1;
          msg_len = target;
        end
      end else if (chunk_prog == hmbd_pkg::CHUNK_LEN) begin
        done = 1'b1;
        msg_len = byte_count;
      end else if (!chunk_wait_cfg) begin
        done = 1'b1;
        msg_len = in_hdr ? hdr_len : byte_count;
      end
    end
    res.complete        = done;
    res.message_length  = done ? msg_len[31:0] : 32'd0;
    res.in_body         = hdr_seen;
    res.length_overflow = saturated;
    if (done) begin
      reset_message_state();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: at each rising edge it checks a result that leaves the block
  // against the oldest prediction, then predicts the result of a request
  // that enters it. A byte's result can never leave on the edge that takes
  // the byte, so this order is safe. The watchdog lives here as well.
  always @(posedge clk_i) begin : monitor
    hmbd_pkg::result_t want;
    hmbd_pkg::result_t pred;
    logic    took_in;
    logic    took_out;
    took_in  = rst_ni && in_ch.valid && in_ch.ready;
    took_out = rst_ni && out_ch.valid && out_ch.ready;
    in_fire <= took_in;
    if (took_out) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("complete", 32'(want.complete), 32'(out_ch.complete));
        check_field("message_length", want.message_length, out_ch.message_length);
        check_field("in_body", 32'(want.in_body), 32'(out_ch.in_body));
        check_field("length_overflow", 32'(want.length_overflow),
                    32'(out_ch.length_overflow));
      end
    end
    if (took_in) begin
      scan_byte(in_ch.data_byte, in_ch.restart, pred);
      expected_results.push_back(pred);
      accepted_total++;
    end
    if (rst_ni) begin
      if (took_in || took_out) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Driver: a request stays on the channel until it is taken; new ones are
  // offered in bursts of random length with random gaps between them, and a
  // gap of zero now and then gives long stretches without idling.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin : driver
    logic         offer;
    stream_byte_t nxt;
    offer = drv_valid && !in_fire;
    nxt   = '{data_byte: drv_data, restart: drv_restart};
    if (rst_ni && !offer) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_bytes.size() > 0) begin
        nxt = pending_bytes.pop_front();
        offer = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
    drv_valid   <= offer;
    drv_data    <= nxt.data_byte;
    drv_restart <= nxt.restart;
  end

  // Receiver: switches between a few stall patterns at random. Twice in the
  // run it holds off for a long stretch while the sender keeps offering, so
  // that both registers of the block fill and its input stalls.
  rx_mode_e    rx_mode     = RX_ALWAYS;
  int unsigned rx_mode_left = 0;
  int unsigned rx_tick     = 0;
  int unsigned hold_left   = 0;
  logic [1:0]  holds_done  = 2'b00;

  always @(negedge clk_i) begin : receiver
    logic rdy;
    rdy = 1'b0;
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (!holds_done[0] && results_seen >= 120) begin
        holds_done[0] = 1'b1;
        hold_left = LONG_HOLD - 1;
      end else if (!holds_done[1] && results_seen >= 480) begin
        holds_done[1] = 1'b1;
        hold_left = LONG_HOLD - 1;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 3));
          rx_mode_left = $urandom_range(20, 80);
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
          RX_ALWAYS:   rdy = 1'b1;
          RX_COIN:     rdy = ($urandom_range(0, 1) == 1);
          RX_MOSTLY:   rdy = ($urandom_range(0, 6) != 0);
          default:     rdy = (rx_tick % 3 != 0);
        endcase
      end
    end
    drv_ready <= rdy;
  end

  // Stimulus helpers. The first byte pushed after next_restart is set carries
  // the restart flag.
  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back('{data_byte: b, restart: next_restart});
    next_restart = 1'b0;
    queued_total++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i]);
    end
  endtask

  task automatic push_eol(input logic lf_only);
    if (!lf_only) begin
      push_byte(hmbd_pkg::CHAR_CR);
    end
    push_byte(hmbd_pkg::CHAR_LF);
  endtask

  // Printable header text, now and then with the top bit set.
  task automatic push_token(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) begin
        push_byte(8'($urandom_range(128, 255)));
      end else begin
        push_byte(8'($urandom_range(32, 126)));
      end
    end
  endtask

  // A length field line in random case with random blanks and a value of a
  // random shape. Returns the body length that the field asks for, or flags
  // a length so large that the message will not finish in this run.
  task automatic push_length_field(input logic lf_only, output int unsigned body_len,
                                   output logic unbounded);
    logic [7:0]  ch;
    int unsigned kind;
    int unsigned v;
    for (int i = 0; i < 15; i++) begin
      ch = FIELD_TEXT[8*(14-i) +: 8];
      if (ch >= "a" && ch <= "z" && $urandom_range(0, 1) == 1) begin
        ch = ch - hmbd_pkg::CASE_OFFSET;
      end
      push_byte(ch);
    end
    repeat ($urandom_range(0, 3)) begin
      push_byte(($urandom_range(0, 1) == 1) ? hmbd_pkg::CHAR_SPACE : hmbd_pkg::CHAR_TAB);
    end
    kind = $urandom_range(0, 19);
    unbounded = 1'b0;
    body_len = 0;
    if (kind <= 11) begin
      v = $urandom_range(0, 12);
      push_text($sformatf("%0d", v));
      body_len = v;
    end else if (kind <= 13) begin
      v = $urandom_range(13, 60);
      push_text($sformatf("%0d", v));
      body_len = v;
    end else if (kind == 14) begin
      // No digits at all: the length is taken as zero.
    end else if (kind == 15) begin
      // A sign ends the parse before any digit.
      push_byte(($urandom_range(0, 1) == 1) ? "+" : "-");
      push_text($sformatf("%0d", $urandom_range(1, 9)));
    end else if (kind == 16) begin
      push_text("007");
      body_len = 7;
    end else if (kind == 17) begin
      v = $urandom_range(0, 9);
      push_text($sformatf("%0d;q", v));
      body_len = v;
    end else if (kind == 18) begin
      // Saturates the parsed value.
      push_text("99999999999");
      unbounded = 1'b1;
    end else begin
      // Fits the value but not the target length.
      push_text("4294967295");
      unbounded = 1'b1;
    end
    push_eol(lf_only);
  endtask

  // One message of random shape: mostly well-formed, sometimes noise or a
  // header that is broken off and thrown away by a restart.
  task automatic gen_message(input logic cw);
    int unsigned style;
    int unsigned nlines;
    int unsigned field_at;
    int unsigned body_len;
    int unsigned spare_len;
    int unsigned nchunks;
    int unsigned csize;
    logic        lf_only;
    logic        has_field;
    logic        unbounded;
    logic        spare_unbounded;
    logic        use_decoy;
    string       decoy;
    decoy = "Content-Length: 3\n\n";
    next_restart = force_restart || ($urandom_range(0, 7) == 0);
    force_restart = 1'b0;
    style = $urandom_range(0, 9);
    if (style == 0) begin
      repeat ($urandom_range(1, 8)) begin
        next_restart = ($urandom_range(0, 3) == 0);
        push_byte(8'($urandom_range(0, 255)));
      end
      force_restart = 1'b1;
      return;
    end
    lf_only = ($urandom_range(0, 2) == 0);
    push_token($urandom_range(3, 14));
    push_eol(lf_only);
    if (style == 1) begin
      push_token($urandom_range(1, 10));
      force_restart = 1'b1;
      return;
    end
    nlines = $urandom_range(0, 3);
    has_field = ($urandom_range(0, 4) != 0);
    field_at = $urandom_range(0, nlines);
    body_len = 0;
    unbounded = 1'b0;
    for (int i = 0; i <= nlines; i++) begin
      if (has_field && i == field_at) begin
        push_length_field(lf_only, body_len, unbounded);
        // A second field in the same header must be ignored.
        if ($urandom_range(0, 3) == 0) begin
          push_length_field(lf_only, spare_len, spare_unbounded);
        end
      end else begin
        push_token($urandom_range(1, 8));
        push_text(": ");
        push_token($urandom_range(1, 8));
        push_eol(lf_only);
      end
    end
    push_eol(lf_only);
    if (has_field) begin
      if (unbounded) begin
        body_len = $urandom_range(0, 6);
        force_restart = 1'b1;
      end
      // The body may hold a length field of its own, which must not count.
      use_decoy = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < body_len; i++) begin
        if (use_decoy) begin
          push_byte(decoy[i % decoy.len()]);
        end else begin
          push_byte(8'($urandom_range(0, 255)));
        end
      end
    end else if (cw) begin
      nchunks = $urandom_range(0, 2);
      // With no chunk the terminator shares the final CR LF of the header.
      if (nchunks == 0 && lf_only) begin
        push_eol(1'b0);
      end
      repeat (nchunks) begin
        csize = $urandom_range(1, 9);
        push_byte(hmbd_pkg::CHAR_ZERO + 8'(csize));
        push_eol(1'b0);
        repeat (csize) begin
          push_byte(8'($urandom_range(0, 255)));
        end
        push_eol(1'b0);
      end
      push_byte(hmbd_pkg::CHAR_ZERO);
      push_eol(1'b0);
      push_eol(1'b0);
    end
  endtask

  // The register is written at a falling edge while nothing is in flight.
  task automatic set_chunk_wait(input logic value);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    chunk_wait_cfg = value;
  endtask

  task automatic wait_until_drained();
    while (accepted_total != queued_total || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Ending at the header, by LF LF after the extreme byte values and by
    // CR LF CR LF; then a restart that throws away a partial message.
    set_chunk_wait(1'b0);
    next_restart = 1'b1;
    push_byte(8'h00);
    push_byte(8'hFF);
    push_eol(1'b1);
    push_eol(1'b1);
    push_eol(1'b0);
    push_eol(1'b0);
    push_text("q");
    next_restart = 1'b1;
    push_eol(1'b1);
    push_eol(1'b1);
    wait_until_drained();

    // The chunk terminator overlapping the header end.
    set_chunk_wait(1'b1);
    push_text("X");
    push_eol(1'b0);
    push_byte(hmbd_pkg::CHAR_ZERO);
    push_eol(1'b0);
    push_eol(1'b0);
    // A message left waiting for its terminator, then chunk_wait cleared in
    // the body: the next byte ends it.
    push_eol(1'b1);
    push_eol(1'b1);
    push_text("a");
    wait_until_drained();
    set_chunk_wait(1'b0);
    push_text("b");
    wait_until_drained();

    for (int p = 0; p < 5; p++) begin
      set_chunk_wait(PHASE_CHUNK_WAIT[p]);
      phase_end = queued_total + PHASE_ITEMS;
      while (queued_total < phase_end) begin
        gen_message(PHASE_CHUNK_WAIT[p]);
      end
      wait_until_drained();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
